### rtl/core/pdr_pkg.sv
// ----------------------------------------------------------------------------
// Planar dead-reckoning package
// Shared types, command and status structs, constants and tables.
// ----------------------------------------------------------------------------
package pdr_pkg;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_G_MUL,
		ST_G_ADD,
		ST_G_WRAP,
		ST_A_AXDT,
		ST_A_AYDT,
		ST_A_VXDT,
		ST_A_PXDT,
		ST_A_VYDT,
		ST_A_PYDT,
		ST_A_SUMB,
		ST_A_BY,
		ST_A_WAIT,
		ST_A_SBY,
		ST_A_SBX,
		ST_A_CBY,
		ST_A_SUMY,
		ST_A_OUT
	} state_t;

	typedef enum logic [3:0] {
		MUL_AXDT,
		MUL_AYDT,
		MUL_VXDT,
		MUL_VYDT,
		MUL_PXDT,
		MUL_PYDT,
		MUL_CBX,
		MUL_SBY,
		MUL_SBX,
		MUL_CBY
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_VEL,
		ACC_POS,
		ACC_ROT0,
		ACC_SUB,
		ACC_ADD
	} acc_op_t;

	typedef enum logic [3:0] {
		WR_NONE,
		WR_PX,
		WR_PY,
		WR_BX,
		WR_BY_VEL,
		WR_WX,
		WR_WY_OUT,
		WR_HSUM,
		WR_HWRAP
	} wr_op_t;

	typedef struct packed {
		logic     load;
		logic     cordic_start;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		wr_op_t   wr;
	} cmd_t;

	typedef struct packed {
		logic hw_ok;
		logic cordic_done;
	} sts_t;

	localparam logic OP_GYRO  = 1'b0;
	localparam logic OP_ACCEL = 1'b1;

	localparam logic CFG_BIAS_X = 1'b0;
	localparam logic CFG_BIAS_Y = 1'b1;

	localparam logic signed [34:0] PI_Q      = 35'sd843314857;
	localparam logic signed [34:0] TWO_PI_Q  = 35'sd1686629713;
	localparam logic signed [33:0] PI_Z      = 34'sd843314857;
	localparam logic signed [33:0] HALF_PI_Z = 34'sd421657428;
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

	localparam logic signed [65:0] RND_BODY = 66'sd16777216;
	localparam logic signed [65:0] RND_ROT  = 66'sd536870912;

	function automatic logic [31:0] atan_q(input logic [4:0] k);
		logic [31:0] r;
		unique case (k)
			5'd0:  r = 32'd210828714;
			5'd1:  r = 32'd124459457;
			5'd2:  r = 32'd65760959;
			5'd3:  r = 32'd33381290;
			5'd4:  r = 32'd16755422;
			5'd5:  r = 32'd8385879;
			5'd6:  r = 32'd4193963;
			5'd7:  r = 32'd2097109;
			5'd8:  r = 32'd1048571;
			5'd9:  r = 32'd524287;
			5'd10: r = 32'd262144;
			5'd11: r = 32'd131072;
			5'd12: r = 32'd65536;
			5'd13: r = 32'd32768;
			5'd14: r = 32'd16384;
			5'd15: r = 32'd8192;
			5'd16: r = 32'd4096;
			5'd17: r = 32'd2048;
			5'd18: r = 32'd1024;
			5'd19: r = 32'd512;
			5'd20: r = 32'd256;
			5'd21: r = 32'd128;
			5'd22: r = 32'd64;
			5'd23: r = 32'd32;
			5'd24: r = 32'd16;
			5'd25: r = 32'd8;
			5'd26: r = 32'd4;
			5'd27: r = 32'd2;
			5'd28: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
		logic signed [31:0] r;
		if (v > 67'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -67'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### rtl/core/pdr_cordic.sv
// ----------------------------------------------------------------------------
// Iterative CORDIC
// Rotation-mode sine and cosine of the heading, one micro-rotation a cycle.
// ----------------------------------------------------------------------------
module pdr_cordic #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] angle,
	output logic               done,
	output logic signed [32:0] cos_o,
	output logic signed [32:0] sin_o
);

	localparam int CW = $clog2(STEPS + 1);

	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic               neg_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [33:0] z_q;
	logic signed [33:0] ang_w;
	logic signed [33:0] z0;
	logic               neg0;
	logic [4:0]         k;
	logic signed [33:0] xs;
	logic signed [33:0] ys;
	logic signed [33:0] at;

	assign ang_w = 34'(angle);
	assign k     = 5'(cnt_q);
	assign xs    = x_q >>> k;
	assign ys    = y_q >>> k;
	assign at    = $signed({2'b00, pdr_pkg::atan_q(k)});

	always_comb begin
		priority if (ang_w > pdr_pkg::HALF_PI_Z) begin
			z0   = ang_w - pdr_pkg::PI_Z;
			neg0 = 1'b1;
		end else if (ang_w < -pdr_pkg::HALF_PI_Z) begin
			z0   = ang_w + pdr_pkg::PI_Z;
			neg0 = 1'b1;
		end else begin
			z0   = ang_w;
			neg0 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= pdr_pkg::CORDIC_X0;
			y_q   <= '0;
			z_q   <= z0;
			neg_q <= neg0;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done  = done_q;
	assign cos_o = neg_q ? 33'(-x_q) : 33'(x_q);
	assign sin_o = neg_q ? 33'(-y_q) : 33'(y_q);

endmodule

### rtl/core/pdr_datapath.sv
// ----------------------------------------------------------------------------
// Dead-reckoning datapath
// State registers, bias registers, shared multiplier, accumulator, CORDIC.
// ----------------------------------------------------------------------------
module pdr_datapath #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pdr_pkg::cmd_t      cmd,
	output pdr_pkg::sts_t      sts,
	input  logic               op,
	input  logic [15:0]        interval,
	input  logic signed [15:0] value_a,
	input  logic signed [15:0] value_b,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic signed [15:0] cfg_data,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y
);

	logic signed [15:0] bias_x_q;
	logic signed [15:0] bias_y_q;
	logic signed [31:0] heading_q;
	logic signed [31:0] vx_q;
	logic signed [31:0] vy_q;
	logic signed [31:0] wx_q;
	logic signed [31:0] wy_q;
	logic [15:0]        dt_q;
	logic signed [16:0] ax_q;
	logic signed [16:0] ay_q;
	logic signed [32:0] px_q;
	logic signed [32:0] py_q;
	logic signed [31:0] bx_q;
	logic signed [31:0] by_q;
	logic signed [34:0] hw_q;
	logic signed [65:0] prod_q;
	logic signed [65:0] acc_q;
	logic signed [31:0] out_x_q;
	logic signed [31:0] out_y_q;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [32:0] dt_w;
	logic signed [32:0] cos_w;
	logic signed [32:0] sin_w;
	logic               cordic_done;
	logic signed [31:0] wy_new;

	pdr_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.cordic_start),
		.angle (heading_q),
		.done  (cordic_done),
		.cos_o (cos_w),
		.sin_o (sin_w)
	);

	assign dt_w = $signed({17'd0, dt_q});

	always_comb begin
		unique case (cmd.mul_sel)
			pdr_pkg::MUL_AXDT: begin mul_a = 33'(ax_q); mul_b = dt_w; end
			pdr_pkg::MUL_AYDT: begin mul_a = 33'(ay_q); mul_b = dt_w; end
			pdr_pkg::MUL_VXDT: begin mul_a = 33'(vx_q); mul_b = dt_w; end
			pdr_pkg::MUL_VYDT: begin mul_a = 33'(vy_q); mul_b = dt_w; end
			pdr_pkg::MUL_PXDT: begin mul_a = px_q;      mul_b = dt_w; end
			pdr_pkg::MUL_PYDT: begin mul_a = py_q;      mul_b = dt_w; end
			pdr_pkg::MUL_CBX:  begin mul_a = cos_w;     mul_b = 33'(bx_q); end
			pdr_pkg::MUL_SBY:  begin mul_a = sin_w;     mul_b = 33'(by_q); end
			pdr_pkg::MUL_SBX:  begin mul_a = sin_w;     mul_b = 33'(bx_q); end
			pdr_pkg::MUL_CBY:  begin mul_a = cos_w;     mul_b = 33'(by_q); end
			default:           begin mul_a = 33'(ax_q); mul_b = dt_w; end
		endcase
	end

	assign wy_new = pdr_pkg::sat32(67'(wy_q) + (67'(acc_q) >>> 30));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_x_q  <= '0;
			bias_y_q  <= '0;
			heading_q <= '0;
			vx_q      <= '0;
			vy_q      <= '0;
			wx_q      <= '0;
			wy_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pdr_pkg::CFG_BIAS_X: bias_x_q <= cfg_data;
					pdr_pkg::CFG_BIAS_Y: bias_y_q <= cfg_data;
				endcase
			end
			unique case (cmd.wr)
				pdr_pkg::WR_BY_VEL: begin
					vx_q <= pdr_pkg::sat32(67'(vx_q) + ((67'(px_q) + 67'sd128) >>> 8));
					vy_q <= pdr_pkg::sat32(67'(vy_q) + ((67'(py_q) + 67'sd128) >>> 8));
				end
				pdr_pkg::WR_WX: wx_q <= pdr_pkg::sat32(67'(wx_q) + (67'(acc_q) >>> 30));
				pdr_pkg::WR_WY_OUT: wy_q <= wy_new;
				pdr_pkg::WR_HWRAP: begin
					if (sts.hw_ok) begin
						heading_q <= hw_q[31:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.load) begin
			dt_q <= interval;
			ay_q <= 17'(value_b) - 17'(bias_y_q);
			if (op == pdr_pkg::OP_ACCEL) begin
				ax_q <= 17'(value_a) - 17'(bias_x_q);
			end else begin
				ax_q <= 17'(value_a);
			end
		end
		unique case (cmd.acc_op)
			pdr_pkg::ACC_VEL:  acc_q <= prod_q <<< 9;
			pdr_pkg::ACC_POS:  acc_q <= acc_q + prod_q + pdr_pkg::RND_BODY;
			pdr_pkg::ACC_ROT0: acc_q <= prod_q + pdr_pkg::RND_ROT;
			pdr_pkg::ACC_SUB:  acc_q <= acc_q - prod_q;
			pdr_pkg::ACC_ADD:  acc_q <= acc_q + prod_q;
			default: ;
		endcase
		unique case (cmd.wr)
			pdr_pkg::WR_PX: px_q <= prod_q[32:0];
			pdr_pkg::WR_PY: py_q <= prod_q[32:0];
			pdr_pkg::WR_BX: bx_q <= pdr_pkg::sat32(67'(acc_q >>> 25));
			pdr_pkg::WR_BY_VEL: by_q <= pdr_pkg::sat32(67'(acc_q >>> 25));
			pdr_pkg::WR_WY_OUT: begin
				out_x_q <= wx_q;
				out_y_q <= wy_new;
			end
			pdr_pkg::WR_HSUM: hw_q <= 35'(heading_q) + $signed(prod_q[34:0]);
			pdr_pkg::WR_HWRAP: begin
				priority if (hw_q >= pdr_pkg::PI_Q) begin
					hw_q <= hw_q - pdr_pkg::TWO_PI_Q;
				end else if (hw_q < -pdr_pkg::PI_Q) begin
					hw_q <= hw_q + pdr_pkg::TWO_PI_Q;
				end else begin
					hw_q <= hw_q;
				end
			end
			default: ;
		endcase
	end

	assign sts.hw_ok       = (hw_q >= -pdr_pkg::PI_Q) && (hw_q < pdr_pkg::PI_Q);
	assign sts.cordic_done = cordic_done;
	assign pos_x           = out_x_q;
	assign pos_y           = out_y_q;

endmodule

### rtl/core/pdr_ctrl.sv
// ----------------------------------------------------------------------------
// Dead-reckoning controller
// Sequences the datapath per request and owns both stream handshakes.
// ----------------------------------------------------------------------------
module pdr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          op,
	output logic          out_valid,
	input  logic          out_ready,
	output pdr_pkg::cmd_t cmd,
	input  pdr_pkg::sts_t sts
);

	pdr_pkg::state_t state_q;
	pdr_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pdr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d          = state_q;
		in_ready         = 1'b0;
		out_load         = 1'b0;
		cmd.load         = 1'b0;
		cmd.cordic_start = 1'b0;
		cmd.mul_sel      = pdr_pkg::MUL_AXDT;
		cmd.acc_op       = pdr_pkg::ACC_HOLD;
		cmd.wr           = pdr_pkg::WR_NONE;
		unique case (state_q)
			pdr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (op == pdr_pkg::OP_ACCEL) begin
						cmd.cordic_start = 1'b1;
						state_d          = pdr_pkg::ST_A_AXDT;
					end else begin
						state_d = pdr_pkg::ST_G_MUL;
					end
				end
			end
			pdr_pkg::ST_G_MUL: state_d = pdr_pkg::ST_G_ADD;
			pdr_pkg::ST_G_ADD: begin
				cmd.wr  = pdr_pkg::WR_HSUM;
				state_d = pdr_pkg::ST_G_WRAP;
			end
			pdr_pkg::ST_G_WRAP: begin
				cmd.wr = pdr_pkg::WR_HWRAP;
				if (sts.hw_ok) begin
					state_d = pdr_pkg::ST_IDLE;
				end
			end
			pdr_pkg::ST_A_AXDT: state_d = pdr_pkg::ST_A_AYDT;
			pdr_pkg::ST_A_AYDT: begin
				cmd.mul_sel = pdr_pkg::MUL_AYDT;
				cmd.wr      = pdr_pkg::WR_PX;
				state_d     = pdr_pkg::ST_A_VXDT;
			end
			pdr_pkg::ST_A_VXDT: begin
				cmd.mul_sel = pdr_pkg::MUL_VXDT;
				cmd.wr      = pdr_pkg::WR_PY;
				state_d     = pdr_pkg::ST_A_PXDT;
			end
			pdr_pkg::ST_A_PXDT: begin
				cmd.mul_sel = pdr_pkg::MUL_PXDT;
				cmd.acc_op  = pdr_pkg::ACC_VEL;
				state_d     = pdr_pkg::ST_A_VYDT;
			end
			pdr_pkg::ST_A_VYDT: begin
				cmd.mul_sel = pdr_pkg::MUL_VYDT;
				cmd.acc_op  = pdr_pkg::ACC_POS;
				state_d     = pdr_pkg::ST_A_PYDT;
			end
			pdr_pkg::ST_A_PYDT: begin
				cmd.mul_sel = pdr_pkg::MUL_PYDT;
				cmd.acc_op  = pdr_pkg::ACC_VEL;
				cmd.wr      = pdr_pkg::WR_BX;
				state_d     = pdr_pkg::ST_A_SUMB;
			end
			pdr_pkg::ST_A_SUMB: begin
				cmd.acc_op = pdr_pkg::ACC_POS;
				state_d    = pdr_pkg::ST_A_BY;
			end
			pdr_pkg::ST_A_BY: begin
				cmd.wr  = pdr_pkg::WR_BY_VEL;
				state_d = pdr_pkg::ST_A_WAIT;
			end
			pdr_pkg::ST_A_WAIT: begin
				cmd.mul_sel = pdr_pkg::MUL_CBX;
				if (sts.cordic_done) begin
					state_d = pdr_pkg::ST_A_SBY;
				end
			end
			pdr_pkg::ST_A_SBY: begin
				cmd.mul_sel = pdr_pkg::MUL_SBY;
				cmd.acc_op  = pdr_pkg::ACC_ROT0;
				state_d     = pdr_pkg::ST_A_SBX;
			end
			pdr_pkg::ST_A_SBX: begin
				cmd.mul_sel = pdr_pkg::MUL_SBX;
				cmd.acc_op  = pdr_pkg::ACC_SUB;
				state_d     = pdr_pkg::ST_A_CBY;
			end
			pdr_pkg::ST_A_CBY: begin
				cmd.mul_sel = pdr_pkg::MUL_CBY;
				cmd.acc_op  = pdr_pkg::ACC_ROT0;
				cmd.wr      = pdr_pkg::WR_WX;
				state_d     = pdr_pkg::ST_A_SUMY;
			end
			pdr_pkg::ST_A_SUMY: begin
				cmd.acc_op = pdr_pkg::ACC_ADD;
				state_d    = pdr_pkg::ST_A_OUT;
			end
			pdr_pkg::ST_A_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.wr   = pdr_pkg::WR_WY_OUT;
					out_load = 1'b1;
					state_d  = pdr_pkg::ST_IDLE;
				end
			end
			default: state_d = pdr_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/planar_dead_reckoning_integrator.sv
// ----------------------------------------------------------------------------
// Planar dead-reckoning integrator
// Gyro request: multiply, add, then wrap checks until the heading is in range again.
// Accel request: the path from accept to the result runs through the iterative CORDIC and
// the single shared 33x33 multiplier; the next request is accepted after the result is committed.
// One request at a time; a finished result waits in the output register.
// Asynchronous active-low reset zeroes heading, velocity, position and bias.
// ----------------------------------------------------------------------------
module planar_dead_reckoning_integrator #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // interval, value_a, value_b
	input  logic [0:0]  s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // pos_x, pos_y
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	pdr_pkg::cmd_t      cmd;
	pdr_pkg::sts_t      sts;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;

	assign cfg_ready = 1'b1;

	pdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.op       (s_axis_tuser[0]),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	pdr_datapath #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.op       (s_axis_tuser[0]),
		.interval (s_axis_tdata[15:0]),
		.value_a  ($signed(s_axis_tdata[31:16])),
		.value_b  ($signed(s_axis_tdata[47:32])),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index[0]),
		.cfg_data ($signed(cfg_data)),
		.pos_x    (pos_x),
		.pos_y    (pos_y)
	);

	assign m_axis_tdata = {pos_y, pos_x};

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while a request is in progress");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.wr == pdr_pkg::WR_WY_OUT))
		else $error("result raised without a position commit");

	a_rotation_after_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul_sel == pdr_pkg::MUL_SBY) |-> sts.cordic_done)
		else $error("rotation started before sine and cosine were ready");
`endif

endmodule

### bench/planar_dead_reckoning_integrator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar dead-reckoning integrator testbench
// Drives gyro and accel requests with random gaps and output stalls, predicts
// heading, velocity and position in a scoreboard and checks every position.
// ----------------------------------------------------------------------------
module planar_dead_reckoning_integrator_tb;

	localparam int CORDIC_STEPS = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic         op;
		logic [15:0]  interval;
		logic [15:0]  value_a;
		logic [15:0]  value_b;
	} sample_t;

	typedef struct {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
	} position_t;

	class position_scoreboard;
		longint bias_x, bias_y;
		longint heading, vel_x, vel_y, world_x, world_y;
		position_t pending[$];
		int mismatches;

		function new();
			bias_x = 0; bias_y = 0; heading = 0;
			vel_x = 0; vel_y = 0; world_x = 0; world_y = 0;
			mismatches = 0;
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function void write_bias(logic idx, logic [15:0] d);
			if (idx == pdr_pkg::CFG_BIAS_X) bias_x = longint'($signed(d));
			else bias_y = longint'($signed(d));
		endfunction

		function void sin_cos(longint ang, output longint c, output longint s);
			longint x, y, z, nx, ny, t;
			bit neg;
			x = pdr_pkg::CORDIC_X0; y = 0; z = ang; neg = 0;
			if (z > pdr_pkg::HALF_PI_Z) begin
				z -= pdr_pkg::PI_Z; neg = 1;
			end else if (z < -pdr_pkg::HALF_PI_Z) begin
				z += pdr_pkg::PI_Z; neg = 1;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				t = longint'(pdr_pkg::atan_q(5'(i)));
				if (z >= 0) begin
					nx = x - (y >>> i); ny = y + (x >>> i); z -= t;
				end else begin
					nx = x + (y >>> i); ny = y - (x >>> i); z += t;
				end
				x = nx; y = ny;
			end
			c = neg ? -x : x;
			s = neg ? -y : y;
		endfunction

		function void note_sample(sample_t sm);
			longint dt, va, vb, ax, ay, bx, by, c, s, dx, dy;
			position_t p;
			dt = longint'(sm.interval);
			va = longint'($signed(sm.value_a));
			vb = longint'($signed(sm.value_b));
			if (sm.op == pdr_pkg::OP_GYRO) begin
				heading += va * dt;
				while (heading >= pdr_pkg::PI_Q) heading -= pdr_pkg::TWO_PI_Q;
				while (heading < -pdr_pkg::PI_Q) heading += pdr_pkg::TWO_PI_Q;
				return;
			end
			ax = va - bias_x;
			ay = vb - bias_y;
			bx = clamp32((vel_x * dt * 512 + ax * dt * dt + (64'sd1 << 24)) >>> 25);
			by = clamp32((vel_y * dt * 512 + ay * dt * dt + (64'sd1 << 24)) >>> 25);
			sin_cos(heading, c, s);
			dx = (c * bx - s * by + (64'sd1 << 29)) >>> 30;
			dy = (s * bx + c * by + (64'sd1 << 29)) >>> 30;
			world_x = clamp32(world_x + dx);
			world_y = clamp32(world_y + dy);
			vel_x = clamp32(vel_x + ((ax * dt + 128) >>> 8));
			vel_y = clamp32(vel_y + ((ay * dt + 128) >>> 8));
			p.pos_x = world_x[31:0];
			p.pos_y = world_y[31:0];
			pending.push_back(p);
		endfunction

		function void check_position(logic [63:0] d);
			position_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected position %h", d);
				return;
			end
			e = pending.pop_front();
			if (d[31:0] !== e.pos_x || d[63:32] !== e.pos_y) begin
				mismatches++;
				if (mismatches <= 10)
					$display("position mismatch: expected x=%h y=%h got x=%h y=%h",
						e.pos_x, e.pos_y, d[31:0], d[63:32]);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;  // interval, value_a, value_b
	logic [0:0]  s_axis_tuser;  // op
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;  // pos_x, pos_y
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;

	position_scoreboard board;
	int  idle_pct;
	int  quiet_cycles;
	bit  timed_out;

	planar_dead_reckoning_integrator #(.CORDIC_STEPS(CORDIC_STEPS)) DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// output stalls
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) board.check_position(m_axis_tdata);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_sample(sample_t sm);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= sm.op;
		s_axis_tdata  <= {sm.value_b, sm.value_a, sm.interval};
		do @(posedge clk); while (!s_axis_tready);
		board.note_sample(sm);
		@(negedge clk);
	endtask

	task automatic write_bias(logic idx, logic [15:0] d);
		s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		board.write_bias(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic sample_t make_sample(logic op, logic [15:0] dt,
			logic [15:0] a, logic [15:0] b);
		sample_t sm;
		sm.op = op; sm.interval = dt; sm.value_a = a; sm.value_b = b;
		return sm;
	endfunction

	function automatic logic [15:0] rand_dt();
		case ($urandom_range(9))
			0: return 16'($urandom_range(65535));
			1: return 16'hffff;
			2: return 16'h0000;
			default: return 16'($urandom_range(2000));
		endcase
	endfunction

	initial begin
		board = new();
		idle_pct = 8;
		timed_out = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_sample(make_sample(pdr_pkg::OP_ACCEL, 16'd0, 16'h7fff, 16'h8000));
		send_sample(make_sample(pdr_pkg::OP_ACCEL, 16'hffff, 16'h7fff, 16'h8000));
		send_sample(make_sample(pdr_pkg::OP_ACCEL, 16'hffff, 16'h7fff, 16'h7fff));
		send_sample(make_sample(pdr_pkg::OP_GYRO, 16'hffff, 16'h7fff, 16'hffff));
		send_sample(make_sample(pdr_pkg::OP_ACCEL, 16'h1000, 16'h0100, 16'hff00));
		send_sample(make_sample(pdr_pkg::OP_GYRO, 16'hffff, 16'h8000, 16'h0000));
		send_sample(make_sample(pdr_pkg::OP_GYRO, 16'hffff, 16'h8000, 16'h0000));
		send_sample(make_sample(pdr_pkg::OP_ACCEL, 16'h8000, 16'h8000, 16'h8000));
		send_sample(make_sample(pdr_pkg::OP_GYRO, 16'd0, 16'h7fff, 16'h0000));
		send_sample(make_sample(pdr_pkg::OP_ACCEL, 16'd0, 16'h0000, 16'h0000));
		for (int k = 0; k < 8; k++) begin
			send_sample(make_sample(pdr_pkg::OP_GYRO, 16'h4000, 16'h6487, 16'h0000));
			send_sample(make_sample(pdr_pkg::OP_ACCEL, 16'h0800, 16'hff00, 16'h0180));
		end
		write_bias(pdr_pkg::CFG_BIAS_X, 16'h7fff);
		write_bias(pdr_pkg::CFG_BIAS_Y, 16'h8000);
		send_sample(make_sample(pdr_pkg::OP_ACCEL, 16'hffff, 16'h8000, 16'h7fff));
		send_sample(make_sample(pdr_pkg::OP_ACCEL, 16'hffff, 16'h8000, 16'h7fff));

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_bias(pdr_pkg::CFG_BIAS_X, 16'h0000);
					write_bias(pdr_pkg::CFG_BIAS_Y, 16'h0000);
				end
				1: begin
					write_bias(pdr_pkg::CFG_BIAS_X, 16'h8000);
					write_bias(pdr_pkg::CFG_BIAS_Y, 16'h7fff);
				end
				default: begin
					write_bias(pdr_pkg::CFG_BIAS_X, 16'($urandom));
					write_bias(pdr_pkg::CFG_BIAS_Y, 16'($urandom));
				end
			endcase
			idle_pct = (phase == 2) ? 0 : 8;
			for (int n = 0; n < 160; n++) begin
				logic op;
				op = $urandom_range(1);
				send_sample(make_sample(op, rand_dt(), 16'($urandom), 16'($urandom)));
			end
		end
		idle_pct = 8;
		s_axis_tvalid <= 1'b0;

		while (board.pending.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
